// ----- rtl/core/swstat_pkg.sv -----
`timescale 1ns / 1ps

package swstat_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned MIN_RUN         = 2;
  localparam int unsigned STAT_W          = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_MIN    = 3'd0,
    STAT_MAX    = 3'd1,
    STAT_MEDIAN = 3'd2,
    STAT_MEAN   = 3'd3,
    STAT_RANGE  = 3'd4,
    STAT_MODE   = 3'd5
  } statistic_e;

  localparam statistic_e STAT_RESET = STAT_MEDIAN;

endpackage

// ----- rtl/core/swstat_in_if.sv -----
`timescale 1ns / 1ps

interface swstat_in_if #(
  parameter int unsigned SAMPLE_BITS = swstat_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

// ----- rtl/core/swstat_out_if.sv -----
`timescale 1ns / 1ps

interface swstat_out_if #(
  parameter int unsigned SAMPLE_BITS = swstat_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] value;
  logic                        overflow;

  modport source (output valid, value, overflow, input ready);
  modport sink   (input valid, value, overflow, output ready);
endinterface

// ----- rtl/core/sorted_window_statistic.sv -----
`timescale 1ns / 1ps
// A word without last is taken back to back; in ready stays high.
// A last word yields its result through S_OUT (min, max, range, mode with a run),
// through S_READ then S_OUT (median, one registered memory read) or through S_DIV
// then S_OUT (mean, or mode with no run: one quotient bit per cycle in S_DIV).
// in ready is low from a last word until its result is in the output register.
// Reset (async, active low) clears window state, selects median, empties the output.
module sorted_window_statistic #(
  parameter int unsigned MAX_SAMPLES = swstat_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = swstat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               statistic_we_i,
  input  logic [swstat_pkg::STAT_W-1:0]      statistic_i,
  swstat_in_if.sink                          in_i,
  swstat_out_if.source                       out_o
);

  // Widths: count holds 0..MAX_SAMPLES, sum holds MAX_SAMPLES full-scale samples.
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int unsigned VAL_W  = SAMPLE_BITS + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned EXT_W  = SUM_W - SAMPLE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_OUT
  } state_e;

  // Where the final value comes from once the window closes.
  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_DIV,
    SRC_MEM
  } src_e;

  state_e                   state_q;
  src_e                     src_q;
  logic [swstat_pkg::STAT_W-1:0] stat_q;

  // Window state
  logic [CNT_W-1:0]              count_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SAMPLE_BITS-1:0] first_q, latest_q, best_q;
  logic [CNT_W-1:0]              run_q, best_len_q;
  logic                          found_q, dropped_q;

  // Result working registers
  logic signed [VAL_W-1:0] res_q;
  logic                    ovf_q;
  logic [IDX_W-1:0]        med_addr_q;
  logic                    div_neg_q;
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        divisor_q;
  logic [CNT_W-1:0]        rem_q;
  logic [STEP_W-1:0]       step_q;

  // Output register
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_ovf_q;

  // Sample store, registered read
  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  logic                          accept;
  logic                          keep;
  logic signed [SAMPLE_BITS-1:0] s;
  logic [CNT_W-1:0]              run_d, count_d, best_len_d;
  logic signed [SUM_W-1:0]       sum_d;
  logic signed [SAMPLE_BITS-1:0] first_d, latest_d, best_d;
  logic                          found_d, new_best;
  logic [SUM_W-1:0]              abs_sum;
  logic signed [VAL_W-1:0]       first_x, latest_x, best_x, direct_val;
  src_e                          src_d;

  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [CNT_W-1:0]        rem_d;
  logic [VAL_W-1:0]        quo_mag;
  logic signed [VAL_W-1:0] mean_val;
  logic signed [VAL_W-1:0] final_val;
  logic                    load_out;

  assign in_i.ready     = (state_q == S_IDLE);
  assign accept         = in_i.valid && in_i.ready;
  assign s              = in_i.sample;
  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.overflow = out_ovf_q;

  // Window update for the word at the input; a full window keeps nothing.
  always_comb begin
    keep = (count_q < CNT_W'(MAX_SAMPLES));
    if (count_q == '0) begin
      run_d = CNT_W'(1);
    end else if (s == latest_q) begin
      run_d = run_q + CNT_W'(1);
    end else begin
      run_d = CNT_W'(1);
    end
    new_best = keep && (run_d >= CNT_W'(swstat_pkg::MIN_RUN)) && (run_d > best_len_q);

    count_d    = keep ? count_q + CNT_W'(1) : count_q;
    sum_d      = keep ? sum_q + {{EXT_W{s[SAMPLE_BITS-1]}}, s} : sum_q;
    first_d    = (keep && count_q == '0) ? s : first_q;
    latest_d   = keep ? s : latest_q;
    best_d     = new_best ? s : best_q;
    best_len_d = new_best ? run_d : best_len_q;
    found_d    = found_q || new_best;

    abs_sum  = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
    first_x  = {first_d[SAMPLE_BITS-1], first_d};
    latest_x = {latest_d[SAMPLE_BITS-1], latest_d};
    best_x   = {best_d[SAMPLE_BITS-1], best_d};

    direct_val = first_x;
    src_d      = SRC_MEM;
    unique case (stat_q)
      swstat_pkg::STAT_MIN: begin
        direct_val = first_x;
        src_d      = SRC_DIRECT;
      end
      swstat_pkg::STAT_MAX: begin
        direct_val = latest_x;
        src_d      = SRC_DIRECT;
      end
      swstat_pkg::STAT_RANGE: begin
        direct_val = latest_x - first_x;
        src_d      = SRC_DIRECT;
      end
      swstat_pkg::STAT_MEAN: begin
        src_d = SRC_DIV;
      end
      swstat_pkg::STAT_MODE: begin
        direct_val = best_x;
        src_d      = found_d ? SRC_DIRECT : SRC_DIV;
      end
      default: begin
        src_d = SRC_MEM;  // median, also for unused selector codes
      end
    endcase
  end

  // Restoring divider step: one quotient bit per cycle, MSB first.
  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    ge     = (rem_sh >= {1'b0, divisor_q});
    rem_d  = ge ? CNT_W'(rem_sh - {1'b0, divisor_q}) : CNT_W'(rem_sh);
  end

  // Mean truncates toward zero: divide the magnitude, then restore the sign.
  assign quo_mag  = quo_q[VAL_W-1:0];
  assign mean_val = div_neg_q ? -$signed(quo_mag) : $signed(quo_mag);

  always_comb begin
    case (src_q)
      SRC_DIV: final_val = mean_val;
      SRC_MEM: final_val = {rd_data_q[SAMPLE_BITS-1], rd_data_q};
      default: final_val = res_q;
    endcase
  end

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      mem[count_q[IDX_W-1:0]] <= s;
    end
    rd_data_q <= mem[med_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_q       <= SRC_DIRECT;
      stat_q      <= swstat_pkg::STAT_RESET;
      count_q     <= '0;
      sum_q       <= '0;
      first_q     <= '0;
      latest_q    <= '0;
      best_q      <= '0;
      run_q       <= '0;
      best_len_q  <= '0;
      found_q     <= 1'b0;
      dropped_q   <= 1'b0;
      res_q       <= '0;
      ovf_q       <= 1'b0;
      med_addr_q  <= '0;
      div_neg_q   <= 1'b0;
      quo_q       <= '0;
      divisor_q   <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (statistic_we_i) begin
        stat_q <= statistic_i;
      end

      // a reload in the same cycle keeps the word valid
      if (out_valid_q && out_o.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.last) begin
              // Close the window: snapshot what the result needs, then clear.
              res_q      <= direct_val;
              src_q      <= src_d;
              ovf_q      <= dropped_q || !keep;
              med_addr_q <= IDX_W'(count_d >> 1);
              div_neg_q  <= sum_d[SUM_W-1];
              quo_q      <= abs_sum;
              divisor_q  <= count_d;
              rem_q      <= '0;
              step_q     <= STEP_W'(SUM_W - 1);
              count_q    <= '0;
              sum_q      <= '0;
              first_q    <= '0;
              latest_q   <= '0;
              best_q     <= '0;
              run_q      <= '0;
              best_len_q <= '0;
              found_q    <= 1'b0;
              dropped_q  <= 1'b0;
              unique case (src_d)
                SRC_DIV: state_q <= S_DIV;
                SRC_MEM: state_q <= S_READ;
                default: state_q <= S_OUT;
              endcase
            end else begin
              count_q    <= count_d;
              sum_q      <= sum_d;
              first_q    <= first_d;
              latest_q   <= latest_d;
              best_q     <= best_d;
              best_len_q <= best_len_d;
              found_q    <= found_d;
              if (keep) begin
                run_q <= run_d;
              end else begin
                dropped_q <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[SUM_W-2:0], ge};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= S_OUT;
          end
        end
        S_READ: begin
          state_q <= S_OUT;  // rd_data_q valid from the next cycle
        end
        S_OUT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_value_q <= final_val;
            out_ovf_q   <= ovf_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/sorted_window_statistic_tb.sv -----
`timescale 1ns / 1ps

module sorted_window_statistic_tb;

  localparam int unsigned DEPTH  = swstat_pkg::MAX_SAMPLES_DEF;
  localparam int unsigned SW     = swstat_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned STAT_W = swstat_pkg::STAT_W;

  // Selector codes past the last statistic; the block treats them as median.
  localparam logic [STAT_W-1:0] STAT_SPARE_6 = 3'd6;
  localparam logic [STAT_W-1:0] STAT_SPARE_7 = 3'd7;

  localparam logic signed [SW-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 24'h800000;

  // Cycles to let pass once the last result is in; the divider is slowest.
  localparam int unsigned SETTLE_CYCLES = 48;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 last;
  } sample_word_t;

  typedef struct packed {
    logic signed [SW:0] value;
    logic               overflow;
  } statistic_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic statistic_we_i;
  logic [STAT_W-1:0] statistic_i;

  swstat_in_if  #(.SAMPLE_BITS(SW)) in_bus ();
  swstat_out_if #(.SAMPLE_BITS(SW)) out_bus ();

  sorted_window_statistic #(
    .MAX_SAMPLES(DEPTH),
    .SAMPLE_BITS(SW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .statistic_we_i(statistic_we_i),
    .statistic_i   (statistic_i),
    .in_i          (in_bus),
    .out_o         (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to go out, and results the window model has predicted.
  sample_word_t    sample_send_q[$];
  statistic_word_t statistic_due_q[$];

  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned failures       = 0;
  bit          idle_on        = 1'b1;

  // ---------------------------------------------------------------------
  // Window model: mirrors the block's window state word by word.
  // ---------------------------------------------------------------------
  logic [STAT_W-1:0]    stat_sel;
  logic signed [SW-1:0] win_store [DEPTH];
  int unsigned          win_count;
  longint               win_sum;
  logic signed [SW-1:0] win_first;
  logic signed [SW-1:0] win_latest;
  int unsigned          run_len;
  logic signed [SW-1:0] mode_val;
  int unsigned          mode_len;
  bit                   mode_seen;
  bit                   win_dropped;

  task automatic clear_window_model();
    win_count   = 0;
    win_sum     = 0;
    win_first   = '0;
    win_latest  = '0;
    run_len     = 0;
    mode_val    = '0;
    mode_len    = 0;
    mode_seen   = 1'b0;
    win_dropped = 1'b0;
  endtask

  // Folds one accepted word into the window; on last, predicts the result.
  task automatic absorb_sample(input logic signed [SW-1:0] s, input logic lst);
    longint          mean;
    longint          v;
    statistic_word_t res;
    if (win_count < DEPTH) begin
      if (win_count == 0) begin
        win_first = s;
        run_len   = 1;
      end else if (s == win_latest) begin
        run_len++;
      end else begin
        run_len = 1;
      end
      // strict > keeps the first of equally long runs
      if (run_len >= swstat_pkg::MIN_RUN && run_len > mode_len) begin
        mode_len  = run_len;
        mode_val  = s;
        mode_seen = 1'b1;
      end
      win_store[win_count] = s;
      win_latest = s;
      win_sum   += longint'(s);
      win_count++;
    end else begin
      // full window: word is dropped but still counts for last
      win_dropped = 1'b1;
    end
    if (lst) begin
      mean = (win_count == 0) ? 0 : win_sum / longint'(win_count);
      case (stat_sel)
        swstat_pkg::STAT_MIN:   v = longint'(win_first);
        swstat_pkg::STAT_MAX:   v = longint'(win_latest);
        swstat_pkg::STAT_MEAN:  v = mean;
        swstat_pkg::STAT_RANGE: v = longint'(win_latest) - longint'(win_first);
        swstat_pkg::STAT_MODE:  v = mode_seen ? longint'(mode_val) : mean;
        default:                v = longint'(win_store[(win_count / 2) % DEPTH]);
      endcase
      res.value    = v[SW:0];
      res.overflow = win_dropped;
      statistic_due_q.push_back(res);
      clear_window_model();
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: pops the send queue, holds a word until it is taken, and
  // inserts random gaps while idling is enabled.
  // ---------------------------------------------------------------------
  int unsigned  src_gap = 0;
  sample_word_t src_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid  <= 1'b0;
      in_bus.sample <= '0;
      in_bus.last   <= 1'b0;
      src_gap = 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (src_gap != 0) begin
        in_bus.valid <= 1'b0;
        src_gap--;
      end else if (sample_send_q.size() != 0) begin
        if (idle_on && $urandom_range(0, 9) == 0) begin
          in_bus.valid <= 1'b0;
          src_gap = $urandom_range(1, 13) - 1;
        end else begin
          src_word = sample_send_q.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.sample <= src_word.sample;
          in_bus.last   <= src_word.last;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, same burst shape as the sender.
  int unsigned snk_stall = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      snk_stall = 0;
    end else if (snk_stall != 0) begin
      out_bus.ready <= 1'b0;
      snk_stall--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_bus.ready <= 1'b0;
      snk_stall = $urandom_range(1, 13) - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: tracks register writes, feeds accepted words to the model and
  // checks every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------
  statistic_word_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_sel = swstat_pkg::STAT_RESET;
      clear_window_model();
    end else begin
      if (statistic_we_i) stat_sel = statistic_i;
      if (in_bus.valid && in_bus.ready) begin
        words_accepted++;
        absorb_sample(in_bus.sample, in_bus.last);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (statistic_due_q.size() == 0) begin
          failures++;
          $display("%t: result with none expected, value %h overflow %b",
                   $time, out_bus.value, out_bus.overflow);
        end else begin
          want = statistic_due_q.pop_front();
          if (out_bus.value !== want.value) begin
            failures++;
            $display("%t: value mismatch, expected %h actual %h",
                     $time, want.value, out_bus.value);
          end
          if (out_bus.overflow !== want.overflow) begin
            failures++;
            $display("%t: overflow mismatch, expected %b actual %b",
                     $time, want.overflow, out_bus.overflow);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_word(input logic signed [SW-1:0] s, input logic lst);
    sample_word_t w;
    w.sample = s;
    w.last   = lst;
    sample_send_q.push_back(w);
    words_queued++;
  endtask

  // Register writes only happen with the block idle, between phases.
  task automatic write_statistic(input logic [STAT_W-1:0] code);
    @(posedge clk_i);
    statistic_we_i <= 1'b1;
    statistic_i    <= code;
    @(posedge clk_i);
    statistic_we_i <= 1'b0;
  endtask

  // Waits until every word is taken and every result is back, then lets
  // the divider latency pass.
  task automatic drain_phase();
    while (words_accepted != words_queued || statistic_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One window of random content. Mostly sorted ascending as the block
  // expects; a narrow value spread gives runs for mode, a few windows are
  // left unsorted so range can go negative.
  task automatic queue_window(input int unsigned len);
    int                   vals[$];
    logic signed [SW-1:0] s24;
    int                   base;
    int unsigned          spread;
    int unsigned          flavor;
    flavor = $urandom_range(0, 99);
    spread = $urandom_range(0, 7);
    s24    = SW'($urandom);
    base   = int'(s24);
    if (base > 8388600) base = 8388600;
    for (int unsigned i = 0; i < len; i++) begin
      if (flavor < 40) begin
        s24 = SW'($urandom);
        vals.push_back(int'(s24));
      end else if (flavor < 85) begin
        vals.push_back(base + int'($urandom_range(0, spread)));
      end else begin
        case ($urandom_range(0, 3))
          0:       vals.push_back(int'(SAMPLE_MIN));
          1:       vals.push_back(int'(SAMPLE_MAX));
          2:       vals.push_back(-1);
          default: vals.push_back(0);
        endcase
      end
    end
    if ($urandom_range(0, 9) != 0) vals.sort();
    for (int unsigned i = 0; i < len; i++)
      push_word(vals[i][SW-1:0], i == len - 1);
  endtask

  // Mostly short windows; some long ones, a few past capacity.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 32);
    if (r < 96) return $urandom_range(33, DEPTH);
    return $urandom_range(DEPTH + 1, DEPTH + 8);
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned       phase_words;
    int unsigned       len;
    logic [STAT_W-1:0] code;

    rst_ni         = 1'b0;
    statistic_we_i = 1'b0;
    statistic_i    = swstat_pkg::STAT_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: median from reset, single word and the full-scale pair.
    push_word(SAMPLE_MAX, 1'b1);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain_phase();

    write_statistic(swstat_pkg::STAT_MIN);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain_phase();

    write_statistic(swstat_pkg::STAT_MAX);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain_phase();

    // mean of -1 over two truncates to zero; then a negative mean
    write_statistic(swstat_pkg::STAT_MEAN);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain_phase();

    // widest range, then an unsorted pair for the most negative range
    write_statistic(swstat_pkg::STAT_RANGE);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MIN, 1'b1);
    drain_phase();

    // longer second run wins; no run falls back to the mean
    write_statistic(swstat_pkg::STAT_MODE);
    push_word(24'sd1, 1'b0);
    push_word(24'sd1, 1'b0);
    push_word(24'sd2, 1'b0);
    push_word(24'sd2, 1'b0);
    push_word(24'sd2, 1'b1);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain_phase();

    // spare selector codes
    write_statistic(STAT_SPARE_6);
    push_word(-24'sd1, 1'b1);
    drain_phase();
    write_statistic(STAT_SPARE_7);
    push_word(-24'sd1, 1'b1);
    drain_phase();

    // Random phases: each selector once in order, then random picks.
    // The last two phases run with no idling on either side.
    for (int unsigned ph = 0; ph < 14; ph++) begin
      if (ph >= 12) idle_on = 1'b0;
      code = (ph < 8) ? ph[STAT_W-1:0] : STAT_W'($urandom_range(0, 7));
      write_statistic(code);
      // full window with median, mean and mode selected
      if (ph == 2 || ph == 3 || ph == 5) queue_window($urandom_range(DEPTH + 1, DEPTH + 6));
      phase_words = 0;
      while (phase_words < 14) begin
        len = pick_length();
        queue_window(len);
        phase_words += len;
      end
      drain_phase();
    end

    if (failures == 0) begin
      $display("sorted_window_statistic_tb: PASS");
    end else begin
      $display("sorted_window_statistic_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("sorted_window_statistic_tb: FAIL");
    $finish;
  end

endmodule

// ----- sorted_window_statistic.f -----
rtl/core/swstat_pkg.sv
rtl/core/swstat_in_if.sv
rtl/core/swstat_out_if.sv
rtl/core/sorted_window_statistic.sv
dv/sorted_window_statistic_tb.sv
